### rtl/core/dns_pkg.sv
// Shared types, constants and the shaping filter coefficients for the
// dither noise shaper. No dependencies; imported by the core modules.
package dns_pkg;

    localparam int TAPS   = 24;
    localparam int TAP_W  = 5;
    localparam int ERR_W  = 19;
    localparam int COEF_W = 19;
    localparam int PROD_W = ERR_W + COEF_W;
    localparam int ACC_W  = 43;
    localparam int AMP_W  = 16;

    localparam logic [AMP_W-1:0] DITHER_AMP_RESET = 16'd256;

    // Input beat: sample in Q24.8, channel, random word in Q1.15.
    typedef struct packed {
        logic signed [31:0] sample;
        logic               channel;
        logic signed [15:0] random_word;
    } req_beat_t;

    // Result beat: shaped value in Q24.8 and the rounded integer.
    typedef struct packed {
        logic signed [31:0] shaped_value;
        logic signed [23:0] quantized;
    } rsp_beat_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic             clr;
        logic             issue;
        logic [TAP_W-1:0] tap;
    } mac_ctl_t;

    // Shaping filter coefficients in Q3.16, newest error on tap zero.
    function automatic logic signed [COEF_W-1:0] shaper_coef(input logic [TAP_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        begin
            case (tap)
                5'd0:    c = -19'sd157336;
                5'd1:    c =  19'sd220282;
                5'd2:    c = -19'sd252530;
                5'd3:    c =  19'sd258353;
                5'd4:    c = -19'sd185816;
                5'd5:    c =  19'sd89150;
                5'd6:    c = -19'sd8658;
                5'd7:    c = -19'sd45213;
                5'd8:    c =  19'sd72134;
                5'd9:    c = -19'sd52776;
                5'd10:   c =  19'sd22205;
                5'd11:   c =  19'sd6366;
                5'd12:   c = -19'sd21545;
                5'd13:   c =  19'sd26294;
                5'd14:   c = -19'sd14611;
                5'd15:   c =  19'sd3470;
                5'd16:   c =  19'sd7000;
                5'd17:   c = -19'sd9065;
                5'd18:   c =  19'sd8920;
                5'd19:   c = -19'sd2570;
                5'd20:   c = -19'sd348;
                5'd21:   c =  19'sd4263;
                5'd22:   c = -19'sd2763;
                5'd23:   c =  19'sd2950;
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

### rtl/core/dither_noise_shaper_unit.sv
// Top level of the dither noise shaper: sequencer, history memory and output stage.
// Depends on dns_pkg, dns_ram and dns_mac.
//
// Each accepted beat adds dither (amplitude register times the random word)
// and subtracts a 24-tap filter of that channel's past quantization errors,
// rounds to a 24-bit integer and stores the new error. The next beat is
// accepted only once an item is finished: the history memory delivers one
// tap per cycle, followed by the multiply-accumulate drain, the shaping,
// sum and rounding steps, the write-back, and the idle state in which the
// next beat is taken.
// A finished result waits in an output register, so a stalled consumer holds
// up only the write-back of the following item. After reset the history
// memory is cleared one entry per cycle while no item is accepted; the
// amplitude register can be written at any time.
module dither_noise_shaper_unit #(
    parameter int CHANNELS = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  dns_pkg::req_beat_t           req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output dns_pkg::rsp_beat_t           rsp,
    input  logic                         cfg_we,
    input  logic [dns_pkg::AMP_W-1:0]    cfg_wdata
);

    import dns_pkg::*;

    localparam int DEPTH  = CHANNELS * TAPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_RUN   = 8'b0000_0100,
        ST_DRAIN = 8'b0000_1000,
        ST_SHAPE = 8'b0001_0000,
        ST_SUM   = 8'b0010_0000,
        ST_ROUND = 8'b0100_0000,
        ST_WRITE = 8'b1000_0000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [AMP_W-1:0]         amp_reg;
    logic signed [31:0]       sample_reg;
    logic [CH_W-1:0]          ch_reg;
    logic signed [15:0]       rnd_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [TAP_W-1:0]         pos_cur_reg;
    logic [TAP_W-1:0]         rd_idx_reg;
    logic [TAP_W-1:0]         tap_reg;
    logic [TAP_W-1:0]         pos_reg [CHANNELS];
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic signed [17:0]       dither_reg;
    logic signed [19:0]       shape_reg;
    logic signed [31:0]       shaped_reg;
    logic signed [23:0]       q_reg;
    logic                     rsp_valid_reg;
    rsp_beat_t                rsp_reg;

    logic                     accept;
    logic                     slot_free;
    logic                     do_write;
    logic                     last_tap;
    logic [CH_W-1:0]          ch_in;
    logic [TAP_W-1:0]         pos_in;
    mac_ctl_t                 mac_ctl;
    logic signed [ACC_W-1:0]  acc;
    logic                     mac_busy;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ERR_W-1:0]         ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ERR_W-1:0]         ram_rdata;
    logic signed [32:0]       dprod;
    logic signed [32:0]       dsum;
    logic signed [ACC_W:0]    shape_sum;
    logic signed [33:0]       shaped_sum;
    logic signed [31:0]       shaped_sat;
    logic signed [32:0]       round_sum;
    logic signed [24:0]       q_wide;
    logic signed [23:0]       q_sat;
    logic signed [33:0]       diff;
    logic signed [ERR_W-1:0]  err;

    // Handshake and channel selection; out-of-range channels use the last one.
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid & req_ready;
    assign slot_free = !rsp_valid_reg | rsp_ready;
    assign do_write  = (state_reg == ST_WRITE) && slot_free;
    assign last_tap  = (tap_reg == TAP_W'(TAPS - 1));
    assign ch_in     = (32'(req.channel) >= CHANNELS) ? CH_W'(CHANNELS - 1)
                                                      : CH_W'(req.channel);
    assign pos_in    = pos_reg[ch_in];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_SHAPE;
                end
            end
            ST_SHAPE: state_next = ST_SUM;
            ST_SUM:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Tap reads: one history word per cycle, oldest-to-newest order reversed.
    assign mac_ctl.clr   = accept;
    assign mac_ctl.issue = (state_reg == ST_RUN);
    assign mac_ctl.tap   = tap_reg;
    assign ram_raddr     = base_reg + ADDR_W'(rd_idx_reg);

    // Memory writes come from the clearing pass or the item write-back.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (do_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = base_reg + ADDR_W'(pos_cur_reg);
            ram_wdata = err;
        end
    end

    // Dither and the rounded, negated filter output.
    always_comb
    begin
        dprod     = $signed({1'b0, amp_reg}) * rnd_reg;
        dsum      = dprod + 33'sd16384;
        shape_sum = -{acc[ACC_W-1], acc} + 44'sh800000;
    end

    // Shaped value, saturated to 32 bits.
    always_comb
    begin
        shaped_sum = {{2{sample_reg[31]}}, sample_reg}
                   + {{16{dither_reg[17]}}, dither_reg}
                   + {{14{shape_reg[19]}}, shape_reg};
        if (shaped_sum[33:31] == 3'b000 || shaped_sum[33:31] == 3'b111)
        begin
            shaped_sat = shaped_sum[31:0];
        end
        else
        begin
            shaped_sat = shaped_sum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // Round half up to an integer and saturate to 24 bits.
    always_comb
    begin
        round_sum = {shaped_reg[31], shaped_reg} + 33'sd128;
        q_wide    = round_sum[32:8];
        if (q_wide[24] == q_wide[23])
        begin
            q_sat = q_wide[23:0];
        end
        else
        begin
            q_sat = q_wide[24] ? 24'sh80_0000 : 24'sh7F_FFFF;
        end
    end

    // Quantization error in Q3.16, clamped.
    always_comb
    begin
        diff = {{2{q_reg[23]}}, q_reg, 8'h00} - {{2{shaped_reg[31]}}, shaped_reg};
        if ((&diff[33:10]) || !(|diff[33:10]))
        begin
            err = {diff[10:0], 8'h00};
        end
        else
        begin
            err = diff[33] ? 19'sh4_0000 : 19'sh3_FFFF;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            amp_reg       <= DITHER_AMP_RESET;
            clr_addr_reg  <= '0;
            tap_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                pos_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                amp_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept)
            begin
                tap_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                tap_reg <= tap_reg + 1'b1;
            end
            if (do_write)
            begin
                pos_reg[ch_reg] <= (pos_cur_reg == '0) ? TAP_W'(TAPS - 1)
                                                       : pos_cur_reg - 1'b1;
                rsp_valid_reg   <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= req.sample;
            rnd_reg     <= req.random_word;
            ch_reg      <= ch_in;
            base_reg    <= ADDR_W'(ch_in) * ADDR_W'(TAPS);
            pos_cur_reg <= pos_in;
            rd_idx_reg  <= (pos_in == TAP_W'(TAPS - 1)) ? '0 : pos_in + 1'b1;
        end
        else if (state_reg == ST_RUN)
        begin
            rd_idx_reg <= (rd_idx_reg == TAP_W'(TAPS - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        if (state_reg == ST_SHAPE)
        begin
            dither_reg <= dsum[32:15];
            shape_reg  <= shape_sum[ACC_W:24];
        end
        if (state_reg == ST_SUM)
        begin
            shaped_reg <= shaped_sat;
        end
        if (state_reg == ST_ROUND)
        begin
            q_reg <= q_sat;
        end
        if (do_write)
        begin
            rsp_reg.shaped_value <= shaped_reg;
            rsp_reg.quantized    <= q_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Error history of all channels, one ring of TAPS words per channel.
    dns_ram #(
        .WIDTH (ERR_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shaping filter accumulation.
    dns_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .rd_data ($signed(ram_rdata)),
        .acc     (acc),
        .busy    (mac_busy)
    );

endmodule

### rtl/core/dns_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module dns_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 48,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/dns_mac.sv
// Pipelined multiply-accumulate over the error history taps.
// Depends on dns_pkg for the coefficient table and the control struct.
module dns_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dns_pkg::mac_ctl_t                ctl,
    input  logic signed [dns_pkg::ERR_W-1:0] rd_data,
    output logic signed [dns_pkg::ACC_W-1:0] acc,
    output logic                             busy
);

    import dns_pkg::*;

    logic                     vld1_reg;
    logic [TAP_W-1:0]         tap1_reg;
    logic                     vld2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // Product of the memory word that arrived and the coefficient of its tap.
    always_comb
    begin
        prod_next = rd_data * shaper_coef(tap1_reg);
    end

    // The accumulator clears at the start of an item and sums exactly.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (vld2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // Pipeline registers: read data stage, product stage, accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            tap1_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            vld1_reg <= ctl.issue;
            vld2_reg <= vld1_reg;
            tap1_reg <= ctl.tap;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc  = acc_reg;
    assign busy = vld1_reg | vld2_reg;

endmodule
